[hw/rtl/lgn_pkg.sv]
// Shared types and constants for the lightmap gain and normalisation pipeline.
`default_nettype none

package lgn_pkg;

   // Number of RGB channels carried through the pipeline.
   localparam int NUM_CHANNELS = 3;

   // Width of one colour channel.
   localparam int CHAN_W = 8;

   // Width of the gain register, unsigned Q4.8.
   localparam int GAIN_W = 12;

   // Width of a channel times gain product.
   localparam int PROD_W = CHAN_W + GAIN_W;

   // Width of a channel times 255, the dividend of the normalising division.
   localparam int NUM_W = 2 * CHAN_W;

   // Number of divider cells, one per quotient bit.
   localparam int NUM_CELLS = CHAN_W;

   // Gain after reset: 1.0 in Q4.8.
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

   // Largest product that still fits full scale: 255.0 in Q12.8.
   localparam logic [PROD_W-1:0] FULL_SCALE_Q = PROD_W'(65280);

   // Word handed from cell to cell along the divider chain.
   typedef struct packed {
      logic [NUM_CHANNELS-1:0][NUM_W-1:0]  num;      // channel times 255
      logic [NUM_CHANNELS-1:0][CHAN_W-1:0] rem;      // partial remainder
      logic [NUM_CHANNELS-1:0][CHAN_W-1:0] quot;     // quotient bits so far
      logic [NUM_CHANNELS-1:0][CHAN_W-1:0] plain;    // product shifted down
      logic [CHAN_W-1:0]                   divisor;  // brightest input channel
      logic                                over;     // brightest product past full scale
      logic                                last;     // end of lightmap marker
   } cell_word_type;

endpackage

`default_nettype wire

[hw/rtl/lgn_front.sv]
// Front cell: gain products, full-scale test and set-up of the divider word.
`default_nettype none

module lgn_front (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire  [lgn_pkg::GAIN_W-1:0]                  gain,
   input  wire                                         valid_i,
   output logic                                        ready_o,
   input  wire  [lgn_pkg::NUM_CHANNELS-1:0][lgn_pkg::CHAN_W-1:0] chan_i,
   input  wire                                         last_i,
   output logic                                        valid_o,
   input  wire                                         ready_i,
   output lgn_pkg::cell_word_type                      word_o
);

   logic                                                 valid_ff;
   logic                                                 valid_in;
   lgn_pkg::cell_word_type                               word_ff;
   lgn_pkg::cell_word_type                               word_in;
   logic [lgn_pkg::NUM_CHANNELS-1:0][lgn_pkg::PROD_W-1:0] prod;
   logic [lgn_pkg::PROD_W-1:0]                           prod_max;
   logic [lgn_pkg::CHAN_W-1:0]                           chan_max;

   // The stage takes a new word whenever it is empty or its word moves on.
   assign ready_o = !valid_ff || ready_i;

   // One product per channel, and the largest channel and product.
   always_comb begin
      for (int ch = 0; ch < lgn_pkg::NUM_CHANNELS; ch++) begin
         prod[ch] = lgn_pkg::PROD_W'(chan_i[ch]) * lgn_pkg::PROD_W'(gain);
      end
      prod_max = prod[0];
      chan_max = chan_i[0];
      for (int ch = 1; ch < lgn_pkg::NUM_CHANNELS; ch++) begin
         if (prod[ch] > prod_max) begin
            prod_max = prod[ch];
         end
         if (chan_i[ch] > chan_max) begin
            chan_max = chan_i[ch];
         end
      end
   end

   // Build the divider word. The common gain cancels in q*255/max q, so the
   // division runs on channel*255 over the brightest channel.
   always_comb begin
      word_in = word_ff;
      if (ready_o) begin
         for (int ch = 0; ch < lgn_pkg::NUM_CHANNELS; ch++) begin
            word_in.num[ch]   = {chan_i[ch], lgn_pkg::CHAN_W'(0)}
                                - lgn_pkg::NUM_W'(chan_i[ch]);
            word_in.rem[ch]   = word_in.num[ch][lgn_pkg::NUM_W-1:lgn_pkg::CHAN_W];
            word_in.quot[ch]  = '0;
            word_in.plain[ch] = prod[ch][2*lgn_pkg::CHAN_W-1:lgn_pkg::CHAN_W];
         end
         word_in.divisor = chan_max;
         word_in.over    = prod_max > lgn_pkg::FULL_SCALE_Q;
         word_in.last    = last_i;
      end
   end

   assign valid_in = ready_o ? valid_i : valid_ff;

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

`default_nettype wire

[hw/rtl/lgn_div_cell.sv]
// Divider cell: one restoring-division step for all three channels.
`default_nettype none

module lgn_div_cell #(
   parameter int BIT_POS = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     valid_i,
   output logic                    ready_o,
   input  lgn_pkg::cell_word_type  word_i,
   output logic                    valid_o,
   input  wire                     ready_i,
   output lgn_pkg::cell_word_type  word_o
);

   logic                                                   valid_ff;
   logic                                                   valid_in;
   lgn_pkg::cell_word_type                                 word_ff;
   lgn_pkg::cell_word_type                                 word_in;
   logic [lgn_pkg::NUM_CHANNELS-1:0][lgn_pkg::CHAN_W:0]    trial;
   logic [lgn_pkg::NUM_CHANNELS-1:0][lgn_pkg::CHAN_W:0]    diff;
   logic [lgn_pkg::NUM_CHANNELS-1:0]                       fits;

   assign ready_o = !valid_ff || ready_i;

   // Bring down the next dividend bit and subtract the divisor where it fits.
   always_comb begin
      word_in = word_ff;
      for (int ch = 0; ch < lgn_pkg::NUM_CHANNELS; ch++) begin
         trial[ch] = {word_i.rem[ch], word_i.num[ch][BIT_POS]};
         diff[ch]  = trial[ch] - {1'b0, word_i.divisor};
         fits[ch]  = trial[ch] >= {1'b0, word_i.divisor};
      end
      if (ready_o) begin
         word_in = word_i;
         for (int ch = 0; ch < lgn_pkg::NUM_CHANNELS; ch++) begin
            word_in.rem[ch]  = fits[ch] ? diff[ch][lgn_pkg::CHAN_W-1:0]
                                        : trial[ch][lgn_pkg::CHAN_W-1:0];
            word_in.quot[ch] = {word_i.quot[ch][lgn_pkg::CHAN_W-2:0], fits[ch]};
         end
      end
   end

   assign valid_in = ready_o ? valid_i : valid_ff;

   // Cell register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

`default_nettype wire

[hw/rtl/lightmap_rgb_gain_normalize.sv]
// Top level of the lightmap RGB gain and hue-preserving normalisation block.
//
//   channel  direction  handshake             contents
//   req_     in         req_tvalid/tready     pixel word and tlast
//   rsp_     out        rsp_tvalid/tready     adjusted pixel word and tlast
//   csr_     in         csr_valid/ready       gain, unsigned Q4.8
//
// One pixel word is taken per clock unless the output stalls. There is one front
// cell for the gain products and full-scale test, then eight divider cells, one
// quotient bit each. Every cell stalls only when it is full and the next cell
// is not taking, so bubbles close up and the last cell is the output register.
// Reset empties all cells and sets the gain to 1.0; csr_ready is always high.
`default_nettype none

module lightmap_rgb_gain_normalize (
   input  wire         clock,
   input  wire         reset,
   // Pixel in: [7:0] red_in, [15:8] green_in, [23:16] blue_in.
   input  wire  [23:0] req_tdata,
   input  wire         req_tlast,
   input  wire         req_tvalid,
   output logic        req_tready,
   // Pixel out: [7:0] red_out, [15:8] green_out, [23:16] blue_out.
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // Gain write.
   input  wire  [11:0] csr_data,
   input  wire         csr_valid,
   output logic        csr_ready
);

   logic [lgn_pkg::GAIN_W-1:0]                                   gain_ff;
   logic [lgn_pkg::GAIN_W-1:0]                                   gain_in;
   logic [lgn_pkg::NUM_CHANNELS-1:0][lgn_pkg::CHAN_W-1:0]        req_chan;
   logic [lgn_pkg::NUM_CELLS:0]                                  chain_valid;
   logic [lgn_pkg::NUM_CELLS:0]                                  chain_ready;
   lgn_pkg::cell_word_type                                       chain_word [lgn_pkg::NUM_CELLS+1];
   lgn_pkg::cell_word_type                                       out_word;
   logic [lgn_pkg::NUM_CHANNELS-1:0][lgn_pkg::CHAN_W-1:0]        out_chan;

   // Gain register, written from the configuration channel.
   assign csr_ready = 1'b1;
   assign gain_in   = (csr_valid && csr_ready) ? csr_data : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= lgn_pkg::GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // Unpack the pixel word.
   assign req_chan = req_tdata;

   // Front cell.
   lgn_front u_front (
      .clock   (clock),
      .reset   (reset),
      .gain    (gain_ff),
      .valid_i (req_tvalid),
      .ready_o (req_tready),
      .chan_i  (req_chan),
      .last_i  (req_tlast),
      .valid_o (chain_valid[0]),
      .ready_i (chain_ready[0]),
      .word_o  (chain_word[0])
   );

   // Divider chain, most significant quotient bit first.
   for (genvar k = 0; k < lgn_pkg::NUM_CELLS; k++) begin : g_cell
      lgn_div_cell #(
         .BIT_POS (lgn_pkg::NUM_CELLS - 1 - k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (chain_valid[k]),
         .ready_o (chain_ready[k]),
         .word_i  (chain_word[k]),
         .valid_o (chain_valid[k+1]),
         .ready_i (chain_ready[k+1]),
         .word_o  (chain_word[k+1])
      );
   end

   // The last cell holds the finished word until the consumer takes it.
   assign chain_ready[lgn_pkg::NUM_CELLS] = rsp_tready;
   assign out_word = chain_word[lgn_pkg::NUM_CELLS];

   // Pick the normalised quotient or the plain shifted product.
   always_comb begin
      for (int ch = 0; ch < lgn_pkg::NUM_CHANNELS; ch++) begin
         out_chan[ch] = out_word.over ? out_word.quot[ch] : out_word.plain[ch];
      end
   end

   assign rsp_tdata  = out_chan;
   assign rsp_tlast  = out_word.last;
   assign rsp_tvalid = chain_valid[lgn_pkg::NUM_CELLS];

`ifndef SYNTHESIS
   // The output is empty in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word valid straight after reset");

   // A normalised pixel has its brightest channel on full scale.
   a_bright_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_word.over |->
         (out_word.quot[0] == 8'hFF) || (out_word.quot[1] == 8'hFF) ||
         (out_word.quot[2] == 8'hFF))
      else $error("normalised pixel without a full-scale channel");

   // Normalisation is only chosen with a non-zero brightest channel.
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] && chain_word[0].over |-> chain_word[0].divisor != '0)
      else $error("normalisation chosen with a zero divisor");

   // The input is refused only while the front cell holds a stalled word.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> chain_valid[0] && !chain_ready[0])
      else $error("input refused with room in the front cell");
`endif

endmodule

`default_nettype wire

[test/pixel_gain_checker.sv]
// Checker for the lightmap gain block: predicts each pixel word and compares results.
module pixel_gain_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire  [23:0] req_tdata,
   input  wire         req_tlast,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [23:0] rsp_tdata,
   input  wire         rsp_tlast,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [11:0] csr_data,
   input  wire         csr_valid,
   input  wire         csr_ready,
   output int          fail_count,
   output int          pending_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [lgn_pkg::CHAN_W-1:0] red;
      logic [lgn_pkg::CHAN_W-1:0] green;
      logic [lgn_pkg::CHAN_W-1:0] blue;
      logic                       last;
   } pixel_type;

   logic [lgn_pkg::GAIN_W-1:0] gain_shadow;
   pixel_type                  expected_pixels[$];
   int                         mismatches = 0;

   // Scale every channel by the gain; if the brightest product passes full
   // scale, divide all three by it so the brightest lands on 255.
   function automatic pixel_type scale_pixel(logic [lgn_pkg::GAIN_W-1:0] g,
                                             logic [23:0] rgb, logic last);
      logic [lgn_pkg::PROD_W-1:0] prod [lgn_pkg::NUM_CHANNELS];
      logic [lgn_pkg::PROD_W-1:0] peak;
      logic [31:0]                scaled;
      logic [lgn_pkg::CHAN_W-1:0] chan [lgn_pkg::NUM_CHANNELS];
      pixel_type                  px;
      peak = '0;
      for (int i = 0; i < lgn_pkg::NUM_CHANNELS; i++) begin
         prod[i] = lgn_pkg::PROD_W'(rgb[i*lgn_pkg::CHAN_W +: lgn_pkg::CHAN_W])
                   * lgn_pkg::PROD_W'(g);
         if (prod[i] > peak) peak = prod[i];
      end
      for (int i = 0; i < lgn_pkg::NUM_CHANNELS; i++) begin
         if (peak > lgn_pkg::FULL_SCALE_Q) begin
            scaled = (32'(prod[i]) * 32'd255) / 32'(peak);
         end else begin
            scaled = 32'(prod[i]) >> 8;
         end
         chan[i] = scaled[lgn_pkg::CHAN_W-1:0];
      end
      px.red   = chan[0];
      px.green = chan[1];
      px.blue  = chan[2];
      px.last  = last;
      return px;
   endfunction

   // Results are checked before new predictions are queued, since a word
   // cannot leave in the same cycle that it enters.
   always @(posedge clock) begin : watch
      pixel_type exp_px;
      pixel_type got_px;
      if (reset) begin
         gain_shadow <= lgn_pkg::GAIN_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) gain_shadow <= csr_data;

         if (rsp_tvalid && rsp_tready) begin
            got_px = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast};
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Unexpected result word: rgb %0d %0d %0d last %0b",
                           got_px.red, got_px.green, got_px.blue, got_px.last);
            end else begin
               exp_px = expected_pixels.pop_front();
               if (got_px.red !== exp_px.red || got_px.green !== exp_px.green ||
                   got_px.blue !== exp_px.blue || got_px.last !== exp_px.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"Mismatch: expected rgb %0d %0d %0d last %0b, ",
                               "got %0d %0d %0d last %0b"},
                              exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                              got_px.red, got_px.green, got_px.blue, got_px.last);
               end
            end
         end

         if (req_tvalid && req_tready)
            expected_pixels = {expected_pixels,
                               scale_pixel(gain_shadow, req_tdata, req_tlast)};
      end
      pending_count <= expected_pixels.size();
      fail_count    <= mismatches;
   end

endmodule

[test/tb_lightmap_rgb_gain_normalize.sv]
// Testbench top for the lightmap gain block: clock, reset, stimulus and verdict.
module tb_lightmap_rgb_gain_normalize;

   localparam int RESET_CYCLES   = 9;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int LONG_HOLD      = 200;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 175;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_mode_type;

   logic        clock;
   logic        reset;
   logic [23:0] req_tdata;   // [7:0] red, [15:8] green, [23:16] blue
   logic        req_tlast;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] rsp_tdata;   // [7:0] red, [15:8] green, [23:16] blue
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [11:0] csr_data;
   logic        csr_valid;
   logic        csr_ready;

   int fail_count;
   int pending_count;
   int hold_requests = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;

   lightmap_rgb_gain_normalize dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   pixel_gain_checker pixel_check (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_data      (csr_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: ends the run when no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Receiver: switches between stall patterns and holds off for a long
   // stretch whenever the stimulus asks for one.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          holds_done;
      rsp_tready = 1'b0;
      mode       = RX_ALWAYS;
      mode_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS:      rsp_tready <= 1'b1;
               RX_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
               RX_EVERY_THIRD: rsp_tready <= (mode_left % 3 == 0);
               default:        rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offers one pixel word, first starting a new burst, in most cases after a gap,
   // when the current one has run out, and returns once the word is taken.
   task automatic offer_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                              logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(posedge clock);
   endtask

   // Gain writes happen only once the pipeline is empty.
   task automatic write_gain(logic [11:0] gain);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= gain;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Extremes, each channel as the brightest, and the full-scale boundary
   // at a gain of 1020 (64 lands exactly on it, 65 passes it).
   task automatic send_edge_pixels();
      offer_pixel(8'd0,   8'd0,   8'd0,   1'b0);
      offer_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      offer_pixel(8'd255, 8'd128, 8'd1,   1'b0);
      offer_pixel(8'd3,   8'd64,  8'd17,  1'b1);
      offer_pixel(8'd0,   8'd65,  8'd64,  1'b0);
      offer_pixel(8'd200, 8'd7,   8'd255, 1'b0);
   endtask

   // Random pixel of a few shapes: uniform, dim, near white, one dominant
   // channel, and grey.
   task automatic send_random_pixel();
      logic [7:0] chan [3];
      logic [7:0] grey;
      int         lead;
      lead = $urandom_range(0, 2);
      grey = 8'($urandom_range(0, 255));
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 4))
            0: chan[i] = 8'($urandom_range(0, 255));
            1: chan[i] = 8'($urandom_range(0, 15));
            2: chan[i] = 8'($urandom_range(240, 255));
            3: chan[i] = (i == lead) ? 8'($urandom_range(192, 255))
                                     : 8'($urandom_range(0, 63));
            default: chan[i] = grey;
         endcase
      end
      offer_pixel(chan[0], chan[1], chan[2], $urandom_range(0, 15) == 0);
   endtask

   // Main stimulus.
   initial begin
      logic [11:0] phase_gains [NUM_PHASES];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      phase_gains = '{12'd4095, 12'd1, 12'd256, 12'd257, 12'd2048, 12'd128,
                      12'd0, 12'd0};
      phase_gains[6] = 12'($urandom_range(0, 4095));
      phase_gains[7] = 12'($urandom_range(0, 4095));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: the reset gain, zero, the largest gain and the
      // gain that puts channel 64 exactly at full scale.
      send_edge_pixels();
      write_gain(12'd0);
      send_edge_pixels();
      write_gain(12'd4095);
      send_edge_pixels();
      write_gain(12'd1020);
      send_edge_pixels();

      // Random part, one gain setting per phase.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_gain(phase_gains[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Long receiver hold-off while words keep being offered.
            if (p == 3 && n == 20) hold_requests++;
            // Mid-phase pause until every word has come back.
            if (p == 5 && n == 90) wait_drained();
            send_random_pixel();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
